@@ hw/rtl/rational_accumulator_gcd_reduce_defines.svh @@
// assertion macros for the rational accumulator
`ifndef RATIONAL_ACCUMULATOR_GCD_REDUCE_DEFINES_SVH
`define RATIONAL_ACCUMULATOR_GCD_REDUCE_DEFINES_SVH
`ifndef SYNTHESIS
`define RAG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RAG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/rag_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rag_pkg
// shared widths, command and status codes for the rational accumulator
// ----------------------------------------------------------------------------
package rag_pkg;
    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [3:0] {
        CMD_SET_NUM  = 4'd0,
        CMD_SET_DEN  = 4'd1,
        CMD_ADD_FRAC = 4'd2,
        CMD_SUB_FRAC = 4'd3,
        CMD_MUL_FRAC = 4'd4,
        CMD_DIV_FRAC = 4'd5,
        CMD_ADD_INT  = 4'd6,
        CMD_SUB_INT  = 4'd7,
        CMD_MUL_INT  = 4'd8,
        CMD_DIV_INT  = 4'd9
    } t_cmd;

    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_REJ = 2'd1;
    localparam logic [1:0] STAT_OVF = 2'd2;

    function automatic t_word w_mag(input t_word v);
        return v[WORD_BITS-1] ? t_word'(-v) : v;
    endfunction
endpackage

@@ hw/rtl/rag_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rag_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "rational_accumulator_gcd_reduce_defines.svh"
module rag_divider (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rag_pkg::t_word i_dividend,
    input  rag_pkg::t_word i_divisor,
    output logic           o_busy,
    output logic           o_done,
    output rag_pkg::t_word o_quot,
    output rag_pkg::t_word o_rem
);
    import rag_pkg::*;

    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy, r_done;
    t_word               r_q, r_r, r_d;
    logic [WORD_BITS:0]  w_sh, w_sub;

    assign w_sh  = {r_r, r_q[WORD_BITS-1]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(WORD_BITS);
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                if (!w_sub[WORD_BITS]) begin
                    r_r <= w_sub[WORD_BITS-1:0];
                    r_q <= {r_q[WORD_BITS-2:0], 1'b1};
                end else begin
                    r_r <= w_sh[WORD_BITS-1:0];
                    r_q <= {r_q[WORD_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

    `RAG_ASSERT_NEXT(a_div_done, i_clk, i_rst_n, r_busy && r_cnt == CNT_BITS'(1), r_done)
    `RAG_ASSERT_IMPL(a_div_idle, i_clk, i_rst_n, r_done, !r_busy)
    `RAG_ASSERT_IMPL(a_div_cnt, i_clk, i_rst_n, r_busy, r_cnt != '0)
endmodule

@@ hw/rtl/rational_accumulator_gcd_reduce.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_accumulator_gcd_reduce
// signed fraction accumulator with gcd reduction after fraction add and subtract
// ----------------------------------------------------------------------------
// One transaction at a time. Set commands and rejected transactions go
// straight to the output state. Integer multiply and divide pass through
// S_M1 and S_M2, fraction multiply and divide through S_M1 to S_M3, and
// integer add and subtract through S_M1, S_M2 and S_SUM. Fraction add and
// subtract also run Euclid's algorithm plus two final divisions on one
// shared radix-2 divider. The result waits in an output register until
// taken; the input is ready again the cycle after.
`include "rational_accumulator_gcd_reduce_defines.svh"
module rational_accumulator_gcd_reduce (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [3:0]                            i_command,
    input  logic signed [rag_pkg::WORD_BITS-1:0]  i_operand_num,
    input  logic signed [rag_pkg::WORD_BITS-1:0]  i_operand_den,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [rag_pkg::WORD_BITS-1:0]  o_numerator,
    output logic signed [rag_pkg::WORD_BITS-1:0]  o_denominator,
    output logic [1:0]                            o_status
);
    import rag_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_M1, S_M2, S_M3, S_SUM, S_NORM, S_GCD, S_GWAIT,
        S_QN, S_QNW, S_QD, S_QDW, S_OUT
    } t_state;

    localparam t_word SIGN = {1'b1, {(WORD_BITS-1){1'b0}}};

    t_state r_state;
    t_cmd   r_cmd;
    t_word  r_num, r_den, r_on, r_od;
    t_word  r_ma, r_mb, r_p1, r_p2;
    t_word  r_ga, r_gb, r_mn, r_md;
    logic   r_sn, r_sd, r_ovf, r_rej;
    logic   r_ovalid;
    logic [1:0] r_status;

    // shared multiplier
    logic [2*WORD_BITS-1:0] w_prod;
    t_word w_xm, w_ym, w_mul;
    logic  w_movf, w_neg;
    assign w_xm   = w_mag(r_ma);
    assign w_ym   = w_mag(r_mb);
    assign w_prod = {{WORD_BITS{1'b0}}, w_xm} * {{WORD_BITS{1'b0}}, w_ym};
    assign w_neg  = r_ma[WORD_BITS-1] ^ r_mb[WORD_BITS-1];
    assign w_mul  = w_neg ? t_word'(-w_prod[WORD_BITS-1:0]) : w_prod[WORD_BITS-1:0];
    assign w_movf = (w_prod[2*WORD_BITS-1:WORD_BITS] != '0) ||
                    (w_prod[WORD_BITS-1:0] > (w_neg ? SIGN : SIGN - 1'b1));

    t_word w_sum;
    logic  w_aovf;
    assign w_sum  = r_p1 + r_p2;
    assign w_aovf = ((r_p1 ^ w_sum) & (r_p2 ^ w_sum) & SIGN) != '0;

    logic w_rej;
    always_comb begin
        unique case (i_command)
            CMD_SET_DEN, CMD_ADD_FRAC, CMD_SUB_FRAC, CMD_MUL_FRAC:
                w_rej = (i_operand_den == '0);
            CMD_DIV_FRAC: w_rej = (i_operand_den == '0) || (i_operand_num == '0);
            CMD_DIV_INT:  w_rej = (i_operand_num == '0);
            default:      w_rej = 1'b0;
        endcase
    end

    logic  w_div_start, w_div_busy, w_div_done;
    t_word w_dvd, w_dvs, w_q, w_r;
    rag_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_dividend(w_dvd), .i_divisor(w_dvs),
        .o_busy(w_div_busy), .o_done(w_div_done), .o_quot(w_q), .o_rem(w_r)
    );
    assign w_div_start = (r_state == S_GCD && r_gb != '0) || r_state == S_QN ||
                         r_state == S_QD;
    always_comb begin
        unique case (r_state)
            S_QN:    begin w_dvd = r_mn; w_dvs = r_ga; end
            S_QD:    begin w_dvd = r_md; w_dvs = r_ga; end
            default: begin w_dvd = r_ga; w_dvs = r_gb; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_num    <= t_word'(1);
            r_den    <= t_word'(1);
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && !r_ovalid) begin
                    r_cmd <= t_cmd'(i_command);
                    r_on  <= i_operand_num;
                    r_od  <= i_operand_den;
                    r_ovf <= 1'b0;
                    r_rej <= w_rej;
                    if (w_rej) begin
                        r_state <= S_OUT;
                    end else begin
                        case (i_command)
                            CMD_SET_NUM: begin
                                r_num   <= i_operand_num;
                                r_state <= S_OUT;
                            end
                            CMD_SET_DEN: begin
                                r_den   <= i_operand_den;
                                r_state <= S_OUT;
                            end
                            CMD_ADD_FRAC, CMD_SUB_FRAC, CMD_MUL_FRAC, CMD_DIV_FRAC,
                            CMD_ADD_INT, CMD_SUB_INT, CMD_MUL_INT, CMD_DIV_INT:
                                r_state <= S_M1;
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_M1: begin
                    // load first product operands, negate operand where needed
                    if ((r_cmd == CMD_SUB_FRAC || r_cmd == CMD_SUB_INT)) begin
                        if (r_on == SIGN) r_ovf <= 1'b1;
                        r_on <= t_word'(-r_on);
                    end
                    unique case (r_cmd)
                        CMD_ADD_FRAC, CMD_SUB_FRAC, CMD_DIV_FRAC: begin
                            r_ma <= r_num; r_mb <= r_od;
                        end
                        CMD_MUL_FRAC, CMD_MUL_INT: begin r_ma <= r_num; r_mb <= r_on; end
                        default: begin
                            r_ma <= r_den;
                            r_mb <= (r_cmd == CMD_SUB_INT) ? t_word'(-r_on) : r_on;
                        end
                    endcase
                    r_state <= S_M2;
                end
                S_M2: begin
                    if (w_movf) r_ovf <= 1'b1;
                    unique case (r_cmd)
                        CMD_ADD_FRAC, CMD_SUB_FRAC: begin
                            r_p1 <= w_mul; r_ma <= r_on; r_mb <= r_den; r_state <= S_M3;
                        end
                        CMD_MUL_FRAC: begin
                            r_p1 <= w_mul; r_ma <= r_den; r_mb <= r_od; r_state <= S_M3;
                        end
                        CMD_DIV_FRAC: begin
                            r_p1 <= w_mul; r_ma <= r_den; r_mb <= r_on; r_state <= S_M3;
                        end
                        CMD_MUL_INT: begin r_num <= w_mul; r_state <= S_OUT; end
                        CMD_DIV_INT: begin r_den <= w_mul; r_state <= S_OUT; end
                        default: begin r_p2 <= w_mul; r_p1 <= r_num; r_state <= S_SUM; end
                    endcase
                end
                S_M3: begin
                    if (w_movf) r_ovf <= 1'b1;
                    unique case (r_cmd)
                        CMD_ADD_FRAC, CMD_SUB_FRAC: begin
                            r_p2 <= w_mul; r_ma <= r_den; r_mb <= r_od; r_state <= S_SUM;
                        end
                        default: begin r_num <= r_p1; r_den <= w_mul; r_state <= S_OUT; end
                    endcase
                end
                S_SUM: begin
                    r_num <= w_sum;
                    if (r_cmd == CMD_ADD_FRAC || r_cmd == CMD_SUB_FRAC) begin
                        if (w_aovf || w_movf) r_ovf <= 1'b1;
                        r_den <= w_mul;
                        r_state <= S_NORM;
                    end else begin
                        if (w_aovf) r_ovf <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_NORM: begin
                    if (r_num == '0) begin
                        if (r_den == SIGN) r_ovf <= 1'b1;
                        r_den <= t_word'(1);
                        r_state <= S_OUT;
                    end else begin
                        if (r_den[WORD_BITS-1] && (r_den == SIGN || r_num == SIGN))
                            r_ovf <= 1'b1;
                        // signs after moving the denominator sign to the numerator
                        r_sn <= r_den[WORD_BITS-1] ? (r_num == SIGN || !r_num[WORD_BITS-1])
                                                   : r_num[WORD_BITS-1];
                        r_sd <= (r_den == SIGN);
                        r_mn <= w_mag(r_num);
                        r_md <= w_mag(r_den);
                        r_ga <= w_mag(r_num);
                        r_gb <= w_mag(r_den);
                        r_state <= S_GCD;
                    end
                end
                S_GCD: r_state <= (r_gb == '0) ? S_QN : S_GWAIT;
                S_GWAIT: if (w_div_done) begin
                    r_ga <= r_gb;
                    r_gb <= w_r;
                    r_state <= S_GCD;
                end
                S_QN: r_state <= S_QNW;
                S_QNW: if (w_div_done) begin
                    r_num <= r_sn ? t_word'(-w_q) : w_q;
                    r_state <= S_QD;
                end
                S_QD: r_state <= S_QDW;
                S_QDW: if (w_div_done) begin
                    r_den <= r_sd ? t_word'(-w_q) : w_q;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_status <= r_rej ? STAT_REJ : (r_ovf ? STAT_OVF : STAT_OK);
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid       = r_ovalid;
    assign o_numerator   = r_num;
    assign o_denominator = r_den;
    assign o_status      = r_status;

    `RAG_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE)
    `RAG_ASSERT_NEXT(a_out_valid, i_clk, i_rst_n, r_state == S_OUT, o_valid)
    `RAG_ASSERT_IMPL(a_div_use, i_clk, i_rst_n, w_div_busy,
        r_state == S_GWAIT || r_state == S_QNW || r_state == S_QDW)
endmodule

@@ tb/tb_rational_accumulator_gcd_reduce.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_accumulator_gcd_reduce
// self-checking bench for the rational accumulator: a directed table then
// random commands, each result compared field by field against known values
// or a predictor of the fraction state, with random gaps on both handshakes
// ----------------------------------------------------------------------------
module tb_rational_accumulator_gcd_reduce;
    import rag_pkg::*;

    localparam int          CLK_HALF    = 6;
    localparam int          N_RANDOM    = 350;
    localparam int          CYCLE_LIMIT = 4000000;
    localparam logic [3:0]  CMD_RSVD_LO = 4'd10;
    localparam logic [3:0]  CMD_RSVD_HI = 4'd15;
    localparam t_word       W_MIN       = 32'h8000_0000;
    localparam t_word       W_MAX       = 32'h7fff_ffff;

    typedef struct {
        logic [3:0] cmd;
        t_word      on;
        t_word      od;
        bit         typed;
        t_word      e_num;
        t_word      e_den;
        logic [1:0] e_st;
    } t_row;

    typedef struct {
        t_word      num;
        t_word      den;
        logic [1:0] st;
    } t_frac_res;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [3:0]         i_command;
    logic signed [31:0] i_operand_num;
    logic signed [31:0] i_operand_den;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_numerator;
    logic signed [31:0] o_denominator;
    logic [1:0]         o_status;

    t_word     acc_num;
    t_word     acc_den;
    bit        acc_ovf;
    t_frac_res pending_fracs[$];
    int        errors;
    int        cycles;
    bit        drain_quiet;

    rational_accumulator_gcd_reduce dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_operand_num (i_operand_num),
        .i_operand_den (i_operand_den),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_numerator   (o_numerator),
        .o_denominator (o_denominator),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_word neg_wrap(input t_word v);
        if (v == W_MIN) acc_ovf = 1'b1;
        return t_word'(-v);
    endfunction

    function automatic t_word add_wrap(input t_word a, input t_word b);
        t_word s;
        s = a + b;
        if (((a ^ s) & (b ^ s)) & W_MIN) acc_ovf = 1'b1;
        return s;
    endfunction

    function automatic t_word mul_wrap(input t_word a, input t_word b);
        longint p;
        p = longint'(signed'(a)) * longint'(signed'(b));
        if (p != longint'(signed'(p[31:0]))) acc_ovf = 1'b1;
        return p[31:0];
    endfunction

    function automatic t_word magnitude(input t_word v);
        return v[31] ? t_word'(-v) : v;
    endfunction

    function automatic void reduce_frac();
        t_word mn, md, a, b, h, qn, qd;
        if (acc_den[31]) begin
            acc_den = neg_wrap(acc_den);
            acc_num = neg_wrap(acc_num);
        end
        if (acc_num == 0) begin
            acc_den = 1;
            return;
        end
        mn = magnitude(acc_num);
        md = magnitude(acc_den);
        a = mn;
        b = md;
        while (b != 0) begin
            h = a % b;
            a = b;
            b = h;
        end
        qn = mn / a;
        qd = md / a;
        acc_num = acc_num[31] ? t_word'(-qn) : qn;
        acc_den = acc_den[31] ? t_word'(-qd) : qd;
    endfunction

    function automatic t_frac_res apply_cmd(input logic [3:0] cmd, input t_word on,
                                            input t_word od);
        t_frac_res r;
        t_word     n;
        bit        rej;
        rej     = 1'b0;
        acc_ovf = 1'b0;
        case (cmd)
            CMD_SET_NUM: acc_num = on;
            CMD_SET_DEN: begin
                if (od == 0) rej = 1'b1;
                else acc_den = od;
            end
            CMD_ADD_FRAC, CMD_SUB_FRAC: begin
                if (od == 0) begin
                    rej = 1'b1;
                end else begin
                    if (cmd == CMD_SUB_FRAC) on = neg_wrap(on);
                    n = add_wrap(mul_wrap(acc_num, od), mul_wrap(on, acc_den));
                    acc_den = mul_wrap(acc_den, od);
                    acc_num = n;
                    reduce_frac();
                end
            end
            CMD_MUL_FRAC: begin
                if (od == 0) begin
                    rej = 1'b1;
                end else begin
                    acc_num = mul_wrap(acc_num, on);
                    acc_den = mul_wrap(acc_den, od);
                end
            end
            CMD_DIV_FRAC: begin
                if (od == 0 || on == 0) begin
                    rej = 1'b1;
                end else begin
                    acc_num = mul_wrap(acc_num, od);
                    acc_den = mul_wrap(acc_den, on);
                end
            end
            CMD_ADD_INT, CMD_SUB_INT: begin
                if (cmd == CMD_SUB_INT) on = neg_wrap(on);
                acc_num = add_wrap(acc_num, mul_wrap(on, acc_den));
            end
            CMD_MUL_INT: acc_num = mul_wrap(acc_num, on);
            CMD_DIV_INT: begin
                if (on == 0) rej = 1'b1;
                else acc_den = mul_wrap(acc_den, on);
            end
            default: ;
        endcase
        r.num = acc_num;
        r.den = acc_den;
        r.st  = rej ? STAT_REJ : (acc_ovf ? STAT_OVF : STAT_OK);
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    function automatic t_word rand_operand();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return W_MIN;
            2:       return W_MAX;
            3:       return 0;
            4:       return $urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff;
            5:       return t_word'(signed'($urandom_range(0, 2000)) - 1000);
            default: return t_word'(signed'($urandom_range(0, 40)) - 20);
        endcase
    endfunction

    task automatic send_item(input logic [3:0] cmd, input t_word on, input t_word od,
                             input bit typed, input t_frac_res typed_res);
        t_frac_res pred;
        int        g;
        g = gap_len();
        if (g > 0) begin
            i_valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_command     = cmd;
        i_operand_num = on;
        i_operand_den = od;
        i_valid       = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pred = apply_cmd(cmd, on, od);
        pending_fracs.push_back(typed ? typed_res : pred);
        @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_frac_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_fracs.size() == 0) begin
                $display("%0t: unexpected transaction num %h den %h st %0d", $time,
                         o_numerator, o_denominator, o_status);
                errors++;
            end else begin
                e = pending_fracs.pop_front();
                if (o_numerator !== e.num) begin
                    $display("%0t: numerator exp %h got %h", $time, e.num, o_numerator);
                    errors++;
                end
                if (o_denominator !== e.den) begin
                    $display("%0t: denominator exp %h got %h", $time, e.den, o_denominator);
                    errors++;
                end
                if (o_status !== e.st) begin
                    $display("%0t: status exp %0d got %0d", $time, e.st, o_status);
                    errors++;
                end
            end
        end
    end

    // result side backpressure
    initial begin
        int stall;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = 0;
            if (!drain_quiet && $urandom_range(0, 3) == 0) stall = gap_len();
            if (stall == 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_row      rows[$];
        t_frac_res tr;
        logic [3:0] c;
        errors        = 0;
        cycles        = 0;
        drain_quiet   = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_command     = CMD_SET_NUM;
        i_operand_num = '0;
        i_operand_den = '0;
        acc_num       = 1;
        acc_den       = 1;
        acc_ovf       = 1'b0;

        // rejections and extremes with known results
        rows.push_back('{CMD_SET_DEN,  0, 0,       1, 1, 1, STAT_REJ});
        rows.push_back('{CMD_SET_NUM,  W_MAX, 0,   1, W_MAX, 1, STAT_OK});
        rows.push_back('{CMD_MUL_INT,  2, 0,       1, 32'hffff_fffe, 1, STAT_OVF});
        rows.push_back('{CMD_SET_NUM,  W_MIN, 5,   1, W_MIN, 1, STAT_OK});
        rows.push_back('{CMD_SUB_INT,  W_MIN, 0,   1, 0, 1, STAT_OVF});
        rows.push_back('{CMD_DIV_INT,  0, 7,       1, 0, 1, STAT_REJ});
        rows.push_back('{CMD_DIV_FRAC, 0, 1,       1, 0, 1, STAT_REJ});
        rows.push_back('{CMD_ADD_FRAC, 3, 0,       1, 0, 1, STAT_REJ});
        rows.push_back('{CMD_SUB_FRAC, 3, 0,       1, 0, 1, STAT_REJ});
        rows.push_back('{CMD_MUL_FRAC, 3, 0,       1, 0, 1, STAT_REJ});
        // predictor checked
        rows.push_back('{CMD_SET_NUM,  5, 0,       0, 0, 0, 0});
        rows.push_back('{CMD_SET_DEN,  0, -3,      0, 0, 0, 0});
        rows.push_back('{CMD_ADD_FRAC, 1, 6,       0, 0, 0, 0});
        rows.push_back('{CMD_SUB_FRAC, -7, 4,      0, 0, 0, 0});
        rows.push_back('{CMD_MUL_FRAC, -6, 10,     0, 0, 0, 0});
        rows.push_back('{CMD_DIV_FRAC, 9, -2,      0, 0, 0, 0});
        rows.push_back('{CMD_ADD_INT,  3, 0,       0, 0, 0, 0});
        rows.push_back('{CMD_SUB_INT,  W_MAX, 0,   0, 0, 0, 0});
        rows.push_back('{CMD_RSVD_LO,  1, 1,       0, 0, 0, 0});
        rows.push_back('{CMD_RSVD_HI,  W_MIN, W_MIN, 0, 0, 0, 0});
        // denominator wraps to zero, then reduce
        rows.push_back('{CMD_SET_DEN,  0, 65536,   0, 0, 0, 0});
        rows.push_back('{CMD_DIV_INT,  65536, 0,   0, 0, 0, 0});
        rows.push_back('{CMD_ADD_FRAC, 1, 1,       0, 0, 0, 0});
        rows.push_back('{CMD_SET_NUM,  W_MIN, 0,   0, 0, 0, 0});
        rows.push_back('{CMD_SUB_FRAC, W_MIN, W_MIN, 0, 0, 0, 0});

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[k]) begin
            tr.num = rows[k].e_num;
            tr.den = rows[k].e_den;
            tr.st  = rows[k].e_st;
            send_item(rows[k].cmd, rows[k].on, rows[k].od, rows[k].typed, tr);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            drain_quiet = ((k / 60) % 3 == 2);
            if ($urandom_range(0, 19) == 0)
                c = 4'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
            else if ($urandom_range(0, 7) == 0)
                c = 4'($urandom_range(CMD_SET_NUM, CMD_SET_DEN));
            else
                c = 4'($urandom_range(CMD_SET_NUM, CMD_DIV_INT));
            send_item(c, rand_operand(), rand_operand(), 1'b0, tr);
        end
        i_valid = 1'b0;

        while (pending_fracs.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
